FILE: hdl/chcs_pkg.sv
// Shared types and constants for the cubic Hermite curve sampler.
// No dependencies; every other file in this block imports this package.

package chcs_pkg;

	localparam int DATA_W      = 32;
	localparam int CNT_W       = 16;
	localparam int LOG2_W      = 3;
	localparam int COEF_W      = 36;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 4 * DATA_W;
	localparam int OUT_TDATA_W = 2 * DATA_W;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LOG2_SAMPLES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS   = 1'b1;

	localparam logic [LOG2_W-1:0] LOG2_SAMPLES_RST = 3'd4;
	localparam logic [CNT_W-1:0]  MAX_POINTS_RST   = 16'hFFFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // latch the incoming point and tangent
		logic coef;      // form the cubic coefficients a2 and a3
		logic init;      // load the forward-difference registers
		logic step;      // emit one sample and advance the differences
		logic last;      // the emitted sample ends this input's results
		logic commit;    // current point becomes the previous point
	} chcs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_room;  // the output register can take a sample this cycle
	} chcs_sts_t;

endpackage

FILE: hdl/chcs_axis.sv
// One axis of the segment evaluator: coefficient setup and a forward-difference
// cubic generator with rounding and saturation. Depends on chcs_pkg.

module chcs_axis #(
	parameter int MAX_LOG2_SAMPLES = 5
) (
	input  logic                                 clk,
	input  chcs_pkg::chcs_cmd_t                  cmd,
	input  logic [chcs_pkg::LOG2_W-1:0]          log2_eff,
	input  logic signed [chcs_pkg::DATA_W-1:0]   p0,
	input  logic signed [chcs_pkg::DATA_W-1:0]   m0,
	input  logic signed [chcs_pkg::DATA_W-1:0]   p1,
	input  logic signed [chcs_pkg::DATA_W-1:0]   m1,
	output logic signed [chcs_pkg::DATA_W-1:0]   sample
);
	import chcs_pkg::*;

	// The scaled cubic stays below 2^(39 + 3*L) in magnitude up to k = S + 1.
	localparam int ACC_W = 41 + 3 * MAX_LOG2_SAMPLES;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(32'sh8000_0000);

	logic signed [COEF_W-1:0] a2_q;
	logic signed [COEF_W-1:0] a3_q;
	logic signed [ACC_W-1:0]  f_q;
	logic signed [ACC_W-1:0]  d1_q;
	logic signed [ACC_W-1:0]  d2_q;
	logic signed [ACC_W-1:0]  d3_q;

	logic signed [COEF_W-1:0] diff;
	logic signed [COEF_W-1:0] m0_c;
	logic signed [COEF_W-1:0] m1_c;
	logic signed [ACC_W-1:0]  a2_e;
	logic signed [ACC_W-1:0]  a3_e;
	logic signed [ACC_W-1:0]  half;
	logic signed [ACC_W-1:0]  shifted;
	logic [3:0]               sh1;
	logic [3:0]               sh2;
	logic [3:0]               sh3;

	assign diff = COEF_W'(p1) - COEF_W'(p0);
	assign m0_c = COEF_W'(m0);
	assign m1_c = COEF_W'(m1);
	assign a2_e = ACC_W'(a2_q);
	assign a3_e = ACC_W'(a3_q);

	assign sh1 = 4'(log2_eff);
	assign sh2 = {log2_eff, 1'b0};
	assign sh3 = sh2 + sh1;

	// The rounding offset is folded into the starting value, so each sample
	// only needs an arithmetic shift, which floors.
	assign half = (sh3 == 4'd0) ? '0 : $signed(ACC_W'(1) << (sh3 - 4'd1));

	always_ff @(posedge clk) begin
		if (cmd.coef) begin
			a2_q <= (diff <<< 1) + diff - (m0_c <<< 1) - m1_c;
			a3_q <= m0_c + m1_c - (diff <<< 1);
		end
		if (cmd.init) begin
			f_q  <= (ACC_W'(p0) <<< sh3) + half;
			d1_q <= (ACC_W'(m0) <<< sh2) + (a2_e <<< sh1) + a3_e;
			d2_q <= (a2_e <<< (sh1 + 4'd1)) + (a3_e <<< 2) + (a3_e <<< 1);
			d3_q <= (a3_e <<< 2) + (a3_e <<< 1);
		end else if (cmd.step) begin
			f_q  <= f_q + d1_q;
			d1_q <= d1_q + d2_q;
			d2_q <= d2_q + d3_q;
		end
	end

	assign shifted = f_q >>> sh3;

	always_comb begin
		if (shifted > SAT_HI) begin
			sample = SAT_HI[DATA_W-1:0];
		end else if (shifted < SAT_LO) begin
			sample = SAT_LO[DATA_W-1:0];
		end else begin
			sample = shifted[DATA_W-1:0];
		end
	end

endmodule

FILE: hdl/chcs_datapath.sv
// Datapath: point and tangent registers, the two axis evaluators and the
// output register. Depends on chcs_pkg and chcs_axis.

module chcs_datapath #(
	parameter int MAX_LOG2_SAMPLES = 5
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  chcs_pkg::chcs_cmd_t                   cmd,
	output chcs_pkg::chcs_sts_t                   sts,
	input  logic [chcs_pkg::LOG2_W-1:0]           log2_eff,
	input  logic [chcs_pkg::IN_TDATA_W-1:0]       s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [chcs_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic                                  m_tlast
);
	import chcs_pkg::*;

	logic signed [DATA_W-1:0] prev_px_q, prev_py_q, prev_mx_q, prev_my_q;
	logic signed [DATA_W-1:0] cur_px_q, cur_py_q, cur_mx_q, cur_my_q;
	logic signed [DATA_W-1:0] x_sample, y_sample;
	logic [OUT_TDATA_W-1:0]   out_data_q;
	logic                     out_last_q;
	logic                     out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cur_px_q <= s_tdata[DATA_W-1:0];
			cur_py_q <= s_tdata[2*DATA_W-1:DATA_W];
			cur_mx_q <= s_tdata[3*DATA_W-1:2*DATA_W];
			cur_my_q <= s_tdata[4*DATA_W-1:3*DATA_W];
		end
		if (cmd.commit) begin
			prev_px_q <= cur_px_q;
			prev_py_q <= cur_py_q;
			prev_mx_q <= cur_mx_q;
			prev_my_q <= cur_my_q;
		end
	end

	chcs_axis #(
		.MAX_LOG2_SAMPLES(MAX_LOG2_SAMPLES)
	) u_axis_x (
		.clk      (clk),
		.cmd      (cmd),
		.log2_eff (log2_eff),
		.p0       (prev_px_q),
		.m0       (prev_mx_q),
		.p1       (cur_px_q),
		.m1       (cur_mx_q),
		.sample   (x_sample)
	);

	chcs_axis #(
		.MAX_LOG2_SAMPLES(MAX_LOG2_SAMPLES)
	) u_axis_y (
		.clk      (clk),
		.cmd      (cmd),
		.log2_eff (log2_eff),
		.p0       (prev_py_q),
		.m0       (prev_my_q),
		.p1       (cur_py_q),
		.m1       (cur_my_q),
		.sample   (y_sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_data_q <= {y_sample, x_sample};
			out_last_q <= cmd.last;
		end
	end

	assign sts.out_room = !out_valid_q || m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_data_q;
	assign m_tlast      = out_last_q;

endmodule

FILE: hdl/chcs_ctrl.sv
// Controller state machine: input handshake, segment sequencing, sample and
// point counting. Depends on chcs_pkg.

module chcs_ctrl #(
	parameter int MAX_LOG2_SAMPLES = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic                           s_tuser,
	input  logic [chcs_pkg::LOG2_W-1:0]    log2_eff,
	input  logic [chcs_pkg::CNT_W-1:0]     max_points,
	input  chcs_pkg::chcs_sts_t            sts,
	output chcs_pkg::chcs_cmd_t            cmd
);
	import chcs_pkg::*;

	localparam int K_W = MAX_LOG2_SAMPLES + 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_COEF   = 3'd1;
	localparam logic [2:0] ST_INIT   = 3'd2;
	localparam logic [2:0] ST_RUN    = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;

	logic [2:0]       state_q, state_d;
	logic             have_prev_q, have_prev_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [K_W-1:0]   k_q, k_d;
	logic [K_W-1:0]   samples;
	logic [CNT_W-1:0] count_eff;
	logic             seg_ok;
	logic             last;

	assign samples   = K_W'(1) << log2_eff;
	assign s_tready  = (state_q == ST_IDLE);
	assign count_eff = s_tuser ? '0 : count_q;
	// A segment runs only with a stored point and room left under the cap.
	assign seg_ok    = have_prev_q && !s_tuser && (count_eff < max_points);
	assign last      = (k_q == samples) || (count_q + CNT_W'(1) == max_points);

	always_comb begin
		state_d     = state_q;
		have_prev_d = have_prev_q;
		count_d     = count_q;
		k_d         = k_q;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					count_d     = count_eff;
					state_d     = seg_ok ? ST_COEF : ST_COMMIT;
				end
			end
			ST_COEF: begin
				cmd.coef = 1'b1;
				state_d  = ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				k_d      = '0;
				state_d  = ST_RUN;
			end
			ST_RUN: begin
				if (sts.out_room) begin
					cmd.step = 1'b1;
					cmd.last = last;
					count_d  = count_q + CNT_W'(1);
					k_d      = k_q + K_W'(1);
					if (last) begin
						state_d = ST_COMMIT;
					end
				end
			end
			ST_COMMIT: begin
				cmd.commit  = 1'b1;
				have_prev_d = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			count_q     <= '0;
			k_q         <= '0;
		end else begin
			state_q     <= state_d;
			have_prev_q <= have_prev_d;
			count_q     <= count_d;
			k_q         <= k_d;
		end
	end

`ifndef SYNTHESIS
	a_step_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> sts.out_room)
		else $error("sample emitted while the output register was full");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.coef, cmd.init, cmd.step, cmd.commit}))
		else $error("more than one datapath command in a cycle");

	a_coef_then_init: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.coef |=> cmd.init)
		else $error("coefficient setup not followed by difference load");

	a_last_then_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && cmd.last) |=> cmd.commit)
		else $error("final sample not followed by point commit");

	a_commit_sets_prev: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (have_prev_q && s_tready))
		else $error("commit did not store the point and return to idle");
`endif

endmodule

FILE: hdl/cubic_hermite_curve_sampler_core.sv
// Top level of the cubic Hermite curve sampler: configuration registers,
// controller and datapath. Depends on chcs_pkg, chcs_ctrl and chcs_datapath.
//
//  Channel  Direction  Handshake            Payload
//  s_*      in         s_tvalid/s_tready    point_x, point_y, slope_x, slope_y; curve_start
//  m_*      out        m_tvalid/m_tready    x_out, y_out; last_sample
//  cfg_*    in         cfg_valid/cfg_ready  register index and write data
//
// A point that yields no samples (first of a curve, or past the cap) is accepted and then stored.
// A point that yields n samples goes through accept, coefficient and difference setup,
// one step per sample, and storing the point; a full segment has 2^log2_samples + 1
// samples.
// The sample loop stalls while the output register stays full.
// Reset is asynchronous; no clearing pass is needed after it.

module cubic_hermite_curve_sampler_core #(
	parameter int MAX_LOG2_SAMPLES = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// point_x [31:0], point_y [63:32], slope_x [95:64], slope_y [127:96]
	input  logic [chcs_pkg::IN_TDATA_W-1:0]      s_tdata,
	// curve_start [0]
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// x_out [31:0], y_out [63:32]
	output logic [chcs_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// last_sample
	output logic                                 m_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [chcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [chcs_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import chcs_pkg::*;

	logic [LOG2_W-1:0] log2_samples_q;
	logic [CNT_W-1:0]  max_points_q;
	logic [LOG2_W-1:0] log2_eff;
	chcs_cmd_t         cmd;
	chcs_sts_t         sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_samples_q <= LOG2_SAMPLES_RST;
			max_points_q   <= MAX_POINTS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LOG2_SAMPLES: log2_samples_q <= cfg_data[LOG2_W-1:0];
				CFG_MAX_POINTS:   max_points_q   <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign log2_eff = (log2_samples_q > LOG2_W'(MAX_LOG2_SAMPLES)) ?
		LOG2_W'(MAX_LOG2_SAMPLES) : log2_samples_q;

	chcs_ctrl #(
		.MAX_LOG2_SAMPLES(MAX_LOG2_SAMPLES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.log2_eff   (log2_eff),
		.max_points (max_points_q),
		.sts        (sts),
		.cmd        (cmd)
	);

	chcs_datapath #(
		.MAX_LOG2_SAMPLES(MAX_LOG2_SAMPLES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.log2_eff (log2_eff),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
